FILE: rtl/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int SEQ_SPACE_DEF = 64;
  localparam logic [15:0] DEFAULT_SWEEP_INTERVAL = 16'd100;
  localparam logic [7:0] PREV_NONE = 8'hFE;
  localparam logic [7:0] PREV_WRAPPED = 8'hFF;

  // entry record layout: key, prev, first_time, total_len, total_frags,
  // got_len, got_frags, seen_map
  localparam int ENTRY_W = 32 + 8 + 32 + 16 + 7 + 16 + 7 + 64;

  typedef enum logic [2:0] {
    ST_COMPLETE     = 3'd0,
    ST_IN_PROGRESS  = 3'd1,
    ST_SKIPPED      = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_OUT_OF_SEQ   = 3'd4,
    ST_ARGS_INVALID = 3'd5,
    ST_TABLE_FULL   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CFG_OOO      = 3'd0,
    CFG_WRAP_EN  = 3'd1,
    CFG_WRAP_VAL = 3'd2,
    CFG_TIMEOUT  = 3'd3,
    CFG_INTERVAL = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_EVAL,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  prev;
    logic [31:0] first_time;
    logic [15:0] total_len;
    logic [6:0]  total_frags;
    logic [15:0] got_len;
    logic [6:0]  got_frags;
    logic [63:0] seen_map;
  } entry_t;

endpackage

FILE: rtl/frt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fragment_reassembly_tracker_top.sv
// Top level of the fragment reassembly tracker.
// A key search walks the table entries (N = TABLE_ENTRIES) in order, each entry taking a
// search and a read state through one RAM port and compare unit; an earlier hit ends the
// walk sooner. The next beat is taken in the cycle after the result strobe. A sweep
// fragment also walks every entry; a timed-out hit reruns the walk once.
// Synchronous reset (rst_n low) clears valid bits and sweep count, loads config defaults.
module fragment_reassembly_tracker_top #(
  parameter int TABLE_ENTRIES = frt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_message_key,
  input  logic [5:0]  in_seq_num,
  input  logic        in_first_seq_known,
  input  logic [5:0]  in_first_seq,
  input  logic        in_is_final,
  input  logic [15:0] in_total_len,
  input  logic [6:0]  in_total_frags,
  input  logic [11:0] in_data_len,
  input  logic [31:0] in_rx_time,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_collected_len,
  output logic [6:0]  out_collected_frags
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

  frt_pkg::state_t state_r, state_nxt;

  logic        ooo_r, wrap_en_r;
  logic [6:0]  wrap_val_r;
  logic [31:0] timeout_r;
  logic [15:0] interval_r;
  logic [15:0] sweep_cnt_r, sweep_cnt_nxt;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // latched fragment
  logic [31:0] key_r;
  logic [5:0]  seq_r, fseq_r;
  logic        fknown_r, final_r;
  logic [15:0] tlen_r;
  logic [6:0]  tfrags_r;
  logic [11:0] dlen_r;
  logic [31:0] rx_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          pass_r, pass_nxt;

  logic [2:0]  st_r, st_nxt;
  logic [15:0] clen_r, clen_nxt;
  logic [6:0]  cfr_r, cfr_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  frt_pkg::entry_t ram_wdata, ram_rdata;

  frt_ram #(.WIDTH(frt_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared unit: timeout compare against whichever entry is read
  logic [32:0] deadline;
  logic        rd_timed_out;
  assign deadline = {1'b0, ram_rdata.first_time} + {1'b0, timeout_r};
  assign rd_timed_out = {1'b0, rx_r} > deadline;

  logic args_bad;
  assign args_bad = (timeout_r == '0) || (ooo_r && wrap_en_r);

  logic [5:0] seq_m, fseq_m;
  assign seq_m  = 6'(32'(in_seq_num) % frt_pkg::SEQ_SPACE_DEF);
  assign fseq_m = 6'(32'(in_first_seq) % frt_pkg::SEQ_SPACE_DEF);

  // lowest free slot
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // fragment evaluation on an entry record
  frt_pkg::entry_t ent, upd;
  logic [2:0]  ev_st;
  logic        ev_write, ev_keep;
  logic        ev_retry;
  logic [16:0] sum_len;
  logic [7:0]  prev_inc;
  logic [15:0] ev_clen;
  logic [6:0]  ev_cfr;
  logic        dup;

  always_comb begin
    ent = ram_rdata;
    if (!hit_r) begin
      ent.key = key_r;
      ent.prev = frt_pkg::PREV_NONE;
      ent.first_time = rx_r;
      ent.total_len = tlen_r;
      ent.total_frags = (tlen_r != '0) ? 7'd0 : tfrags_r;
      ent.got_len = '0;
      ent.got_frags = '0;
      ent.seen_map = '0;
    end
    prev_inc = ent.prev + 8'd1;
    if (wrap_en_r && seq_r == '0 && {1'b0, wrap_val_r} == prev_inc) begin
      ent.prev = frt_pkg::PREV_WRAPPED;
    end
    // expected next sequence after a possible wrap
    prev_inc = ent.prev + 8'd1;
    upd = ent;
    ev_st = frt_pkg::ST_IN_PROGRESS;
    ev_write = 1'b0;
    ev_keep = 1'b1;
    ev_retry = 1'b0;
    ev_clen = '0;
    ev_cfr = '0;
    sum_len = '0;
    dup = 1'b0;
    // first_time on a new entry is rx itself, never timed out
    if (hit_r && rd_timed_out) begin
      ev_retry = 1'b1;
      ev_keep = 1'b0;
    end else begin
      if (ooo_r) begin
        dup = ent.seen_map[seq_r];
      end else begin
        dup = (ent.prev == {2'b00, seq_r}) ||
              (!wrap_en_r && !ent.prev[7] && ({2'b00, seq_r} < ent.prev));
      end
      if (dup) begin
        ev_st = frt_pkg::ST_DUPLICATE;
        ev_clen = ent.got_len;
        ev_cfr = ent.got_frags;
        ev_write = !hit_r || (ent.prev != ram_rdata.prev);
      end else if (!ooo_r && ent.prev != frt_pkg::PREV_NONE &&
                   prev_inc != {2'b00, seq_r}) begin
        ev_st = frt_pkg::ST_OUT_OF_SEQ;
        ev_keep = 1'b0;
      end else begin
        if (ooo_r) begin
          upd.seen_map[seq_r] = 1'b1;
          if (ent.total_len == '0 && tlen_r != '0) begin
            upd.total_len = tlen_r;
          end else if (ent.total_frags == '0 && tfrags_r != '0) begin
            upd.total_frags = tfrags_r;
          end
        end else begin
          upd.prev = {2'b00, seq_r};
        end
        sum_len = {1'b0, ent.got_len} + 17'(dlen_r);
        upd.got_len = sum_len[16] ? 16'hFFFF : sum_len[15:0];
        if (ent.got_frags != 7'h7F) begin
          upd.got_frags = ent.got_frags + 7'd1;
        end
        if (upd.total_len != '0) begin
          ev_st = (upd.got_len >= upd.total_len) ? frt_pkg::ST_COMPLETE
                                                 : frt_pkg::ST_IN_PROGRESS;
        end else if (upd.total_frags != '0) begin
          ev_st = (upd.got_frags >= upd.total_frags) ? frt_pkg::ST_COMPLETE
                                                     : frt_pkg::ST_IN_PROGRESS;
        end else begin
          ev_st = final_r ? frt_pkg::ST_COMPLETE : frt_pkg::ST_IN_PROGRESS;
        end
        ev_clen = upd.got_len;
        ev_cfr = upd.got_frags;
        ev_write = 1'b1;
        if (ev_st == frt_pkg::ST_COMPLETE) begin
          ev_keep = 1'b0;
        end
      end
    end
  end

  logic [15:0] eff_interval;
  logic [16:0] cnt_inc;
  assign eff_interval = (interval_r == '0) ? frt_pkg::DEFAULT_SWEEP_INTERVAL : interval_r;
  assign cnt_inc = {1'b0, sweep_cnt_r} + 17'd1;

  logic [IW-1:0] idx_lo;
  assign idx_lo = idx_r[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    pass_nxt = pass_r;
    st_nxt = st_r;
    clen_nxt = clen_r;
    cfr_nxt = cfr_r;
    valid_nxt = valid_r;
    sweep_cnt_nxt = sweep_cnt_r;
    ram_we = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = upd;
    ram_raddr = idx_lo;
    unique case (state_r)
      frt_pkg::S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        pass_nxt = 1'b0;
        if (start) begin
          if (args_bad) begin
            st_nxt = frt_pkg::ST_ARGS_INVALID;
            clen_nxt = '0;
            cfr_nxt = '0;
            state_nxt = frt_pkg::S_DONE;
          end else begin
            state_nxt = frt_pkg::S_SEARCH;
          end
        end
      end
      frt_pkg::S_SEARCH: begin
        // read issued at idx; compare next cycle
        state_nxt = frt_pkg::S_READ;
      end
      frt_pkg::S_READ: begin
        if (valid_r[idx_lo] && ram_rdata.key == key_r) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = idx_lo;
          ram_raddr = idx_lo;
          state_nxt = frt_pkg::S_EVAL;
        end else if (idx_r == LAST) begin
          hit_nxt = 1'b0;
          state_nxt = frt_pkg::S_EVAL;
          if (ooo_r) begin
            if (fknown_r && fseq_r == seq_r && final_r) begin
              st_nxt = frt_pkg::ST_SKIPPED;
            end
          end else if (fknown_r && fseq_r != seq_r) begin
            st_nxt = frt_pkg::ST_OUT_OF_SEQ;
          end else if (final_r) begin
            st_nxt = frt_pkg::ST_SKIPPED;
          end
          if (!((ooo_r && fknown_r && fseq_r == seq_r && final_r) ||
                (!ooo_r && ((fknown_r && fseq_r != seq_r) || final_r)))) begin
            if (free_found) begin
              hit_idx_nxt = free_idx;
              st_nxt = frt_pkg::ST_IN_PROGRESS;
            end else begin
              st_nxt = frt_pkg::ST_TABLE_FULL;
            end
          end
          if (st_nxt != frt_pkg::ST_IN_PROGRESS) begin
            clen_nxt = '0;
            cfr_nxt = '0;
            state_nxt = frt_pkg::S_SWEEP_RD;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          ram_raddr = IW'(idx_r + CW'(1));
          state_nxt = frt_pkg::S_SEARCH;
        end
      end
      frt_pkg::S_EVAL: begin
        if (ev_retry && !pass_r) begin
          valid_nxt[hit_idx_r] = 1'b0;
          pass_nxt = 1'b1;
          hit_nxt = 1'b0;
          idx_nxt = '0;
          ram_raddr = '0;
          state_nxt = frt_pkg::S_SEARCH;
        end else begin
          ram_we = ev_write && !ev_retry;
          valid_nxt[hit_idx_r] = ev_keep;
          st_nxt = ev_retry ? frt_pkg::ST_IN_PROGRESS : ev_st;
          clen_nxt = ev_retry ? 16'd0 : ev_clen;
          cfr_nxt = ev_retry ? 7'd0 : ev_cfr;
          state_nxt = frt_pkg::S_SWEEP_RD;
        end
        idx_nxt = '0;
      end
      frt_pkg::S_SWEEP_RD: begin
        if (cnt_inc > {1'b0, eff_interval}) begin
          sweep_cnt_nxt = '0;
          ram_raddr = '0;
          idx_nxt = '0;
          state_nxt = frt_pkg::S_SWEEP_CHK;
        end else begin
          sweep_cnt_nxt = cnt_inc[15:0];
          state_nxt = frt_pkg::S_DONE;
        end
      end
      frt_pkg::S_SWEEP_CHK: begin
        // one entry per cycle: data for idx arrives now, next read issued
        if (idx_r[CW-1] == 1'b0 || TABLE_ENTRIES == 1 || idx_r <= LAST) begin
          if (valid_r[idx_lo] && rd_timed_out) begin
            valid_nxt[idx_lo] = 1'b0;
          end
        end
        ram_raddr = IW'(idx_r + CW'(1));
        idx_nxt = idx_r + CW'(1);
        if (idx_r == LAST) begin
          state_nxt = frt_pkg::S_DONE;
        end
      end
      frt_pkg::S_DONE: begin
        state_nxt = frt_pkg::S_IDLE;
      end
      default: state_nxt = frt_pkg::S_IDLE;
    endcase
  end

  // S_SWEEP_CHK needs the first read issued ahead of it: insert it via S_SWEEP_RD
  // by reading address 0 there; data arrives when entering S_SWEEP_CHK.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frt_pkg::S_IDLE;
      valid_r <= '0;
      sweep_cnt_r <= '0;
      ooo_r <= 1'b0;
      wrap_en_r <= 1'b0;
      wrap_val_r <= 7'd64;
      timeout_r <= 32'd1000;
      interval_r <= 16'd100;
      idx_r <= '0;
      hit_r <= 1'b0;
      pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      idx_r <= idx_nxt;
      hit_r <= hit_nxt;
      pass_r <= pass_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          frt_pkg::CFG_OOO:      ooo_r <= cfg_wdata[0];
          frt_pkg::CFG_WRAP_EN:  wrap_en_r <= cfg_wdata[0];
          frt_pkg::CFG_WRAP_VAL: wrap_val_r <= cfg_wdata[6:0];
          frt_pkg::CFG_TIMEOUT:  timeout_r <= cfg_wdata;
          frt_pkg::CFG_INTERVAL: interval_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r <= hit_idx_nxt;
    st_r <= st_nxt;
    clen_r <= clen_nxt;
    cfr_r <= cfr_nxt;
    if (state_r == frt_pkg::S_IDLE && start) begin
      key_r <= in_message_key;
      seq_r <= seq_m;
      fknown_r <= in_first_seq_known;
      fseq_r <= fseq_m;
      final_r <= in_is_final;
      tlen_r <= in_total_len;
      tfrags_r <= in_total_frags;
      dlen_r <= in_data_len;
      rx_r <= in_rx_time;
    end
  end

  assign busy = (state_r != frt_pkg::S_IDLE);
  assign out_valid = (state_r == frt_pkg::S_DONE);
  assign out_status = st_r;
  assign out_collected_len = clen_r;
  assign out_collected_frags = cfr_r;

endmodule

FILE: rtl/frt_checker.sv
// Port-level checker for the fragment reassembly tracker, bound to the top level.
module frt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [15:0] out_collected_len,
  input logic [6:0]  out_collected_frags
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_out_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result");

  a_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == frt_pkg::ST_SKIPPED ||
                   out_status == frt_pkg::ST_OUT_OF_SEQ ||
                   out_status == frt_pkg::ST_ARGS_INVALID ||
                   out_status == frt_pkg::ST_TABLE_FULL))
      |-> (out_collected_len == '0 && out_collected_frags == '0))
    else $error("nonzero counts on a rejecting status");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_collected_len   (out_collected_len),
  .out_collected_frags (out_collected_frags)
);

FILE: tb/tb.sv
// Self-checking testbench for the fragment reassembly tracker.
module tb;

  typedef struct {
    logic [31:0] key;
    logic [5:0]  seq;
    logic        fsk;
    logic [5:0]  first_seq;
    logic        fin;
    logic [15:0] tlen;
    logic [6:0]  tfrags;
    logic [11:0] dlen;
    logic [31:0] rx;
  } frag_t;

  typedef struct {
    frt_pkg::status_t st;
    logic [15:0] len;
    logic [6:0]  frags;
  } frag_status_t;

  class reasm_ledger;
    bit          ooo, wrap_en;
    bit [6:0]    wrap_val;
    bit [31:0]   tmo;
    bit [15:0]   interval;
    bit          valid[16];
    bit [31:0]   key_a[16];
    int          prev[16];
    bit [31:0]   t0[16];
    int          tlen_a[16], tfr_a[16], glen[16], gfr[16];
    bit [63:0]   seen[16];
    int          sweep_cnt;
    frag_status_t pending[$];
    int          errors;

    function new();
      ooo = 0; wrap_en = 0; wrap_val = 64; tmo = 1000; interval = 100;
      sweep_cnt = 0; errors = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function void write_reg(frt_pkg::cfg_idx_t idx, bit [31:0] v);
      case (idx)
        frt_pkg::CFG_OOO:      ooo = v[0];
        frt_pkg::CFG_WRAP_EN:  wrap_en = v[0];
        frt_pkg::CFG_WRAP_VAL: wrap_val = v[6:0];
        frt_pkg::CFG_TIMEOUT:  tmo = v;
        frt_pkg::CFG_INTERVAL: interval = v[15:0];
        default: ;
      endcase
    endfunction

    function bit expired(bit [31:0] now, bit [31:0] first);
      return tmo != 0 && {1'b0, now} > ({1'b0, first} + {1'b0, tmo});
    endfunction

    function int find_key(bit [31:0] k);
      for (int i = 0; i < 16; i++) if (valid[i] && key_a[i] == k) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < 16; i++) if (!valid[i]) return i;
      return -1;
    endfunction

    function void note_fragment(frag_t f);
      frag_status_t r;
      int e, seq, pv, lim, nxt;
      bit dup;
      r.st = frt_pkg::ST_IN_PROGRESS; r.len = 0; r.frags = 0;
      seq = int'(f.seq);
      if (tmo == 0 || (ooo && wrap_en)) begin
        r.st = frt_pkg::ST_ARGS_INVALID;
        pending.push_back(r);
        return;
      end
      e = -1;
      for (int pass = 0; pass < 2; pass++) begin
        e = find_key(f.key);
        if (e < 0) begin
          if (ooo) begin
            if (f.fsk && f.first_seq == f.seq && f.fin) begin
              r.st = frt_pkg::ST_SKIPPED; break;
            end
          end else begin
            if (f.fsk && f.first_seq != f.seq) begin
              r.st = frt_pkg::ST_OUT_OF_SEQ; break;
            end
            if (f.fin) begin
              r.st = frt_pkg::ST_SKIPPED; break;
            end
          end
          e = find_free();
          if (e < 0) begin
            r.st = frt_pkg::ST_TABLE_FULL; break;
          end
          valid[e] = 1; key_a[e] = f.key; prev[e] = -2; t0[e] = f.rx;
          tlen_a[e] = int'(f.tlen); tfr_a[e] = f.tlen > 0 ? 0 : int'(f.tfrags);
          glen[e] = 0; gfr[e] = 0; seen[e] = 0;
        end
        if (wrap_en && seq == 0 && int'(wrap_val) == prev[e] + 1) prev[e] = -1;
        if (expired(f.rx, t0[e])) begin
          valid[e] = 0; e = -1;
          continue;
        end
        break;
      end

      if (e >= 0 && r.st == frt_pkg::ST_IN_PROGRESS) begin
        pv = prev[e];
        if (ooo) dup = seen[e][seq];
        else dup = pv == seq || (!wrap_en && seq < pv);
        if (dup) begin
          r.st = frt_pkg::ST_DUPLICATE; r.len = 16'(glen[e]); r.frags = 7'(gfr[e]);
        end else if (!ooo && pv != -2 && pv + 1 != seq) begin
          valid[e] = 0; r.st = frt_pkg::ST_OUT_OF_SEQ;
        end else begin
          if (ooo) begin
            seen[e][seq] = 1'b1;
            if (tlen_a[e] == 0 && f.tlen > 0) tlen_a[e] = int'(f.tlen);
            else if (tfr_a[e] == 0 && f.tfrags > 0) tfr_a[e] = int'(f.tfrags);
          end else begin
            prev[e] = seq;
          end
          glen[e] += int'(f.dlen);
          if (glen[e] > 65535) glen[e] = 65535;
          if (gfr[e] < 127) gfr[e]++;
          if (tlen_a[e] > 0)
            r.st = glen[e] >= tlen_a[e] ? frt_pkg::ST_COMPLETE : frt_pkg::ST_IN_PROGRESS;
          else if (tfr_a[e] > 0)
            r.st = gfr[e] >= tfr_a[e] ? frt_pkg::ST_COMPLETE : frt_pkg::ST_IN_PROGRESS;
          else r.st = f.fin ? frt_pkg::ST_COMPLETE : frt_pkg::ST_IN_PROGRESS;
          r.len = 16'(glen[e]); r.frags = 7'(gfr[e]);
          if (r.st == frt_pkg::ST_COMPLETE) valid[e] = 0;
        end
      end

      lim = interval == 0 ? 100 : int'(interval);
      nxt = sweep_cnt + 1;
      if (nxt > lim) begin
        for (int i = 0; i < 16; i++) if (valid[i] && expired(f.rx, t0[i])) valid[i] = 0;
        sweep_cnt = 0;
      end else begin
        sweep_cnt = nxt & 16'hFFFF;
      end
      pending.push_back(r);
    endfunction

    function void check_status(logic [2:0] st, logic [15:0] len, logic [6:0] frags);
      frag_status_t x;
      if (pending.size() == 0) begin
        $error("status beat with nothing pending: status %0d", st);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (st !== x.st) begin
        $error("status: expected %0d, got %0d", x.st, st); errors++;
      end
      if (len !== x.len) begin
        $error("collected_len: expected %0d, got %0d", x.len, len); errors++;
      end
      if (frags !== x.frags) begin
        $error("collected_frags: expected %0d, got %0d", x.frags, frags); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] in_message_key = 0;
  logic [5:0]  in_seq_num = 0;
  logic        in_first_seq_known = 0;
  logic [5:0]  in_first_seq = 0;
  logic        in_is_final = 0;
  logic [15:0] in_total_len = 0;
  logic [6:0]  in_total_frags = 0;
  logic [11:0] in_data_len = 0;
  logic [31:0] in_rx_time = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_collected_len;
  logic [6:0]  out_collected_frags;

  reasm_ledger ledger = new();

  bit [31:0] key_pool[20];
  int        next_seq[20];
  bit [31:0] now_ticks;

  fragment_reassembly_tracker_top uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk)
    if (rst_n && out_valid) ledger.check_status(out_status, out_collected_len, out_collected_frags);

  initial begin
    #(8 * 3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // start stays high across back-to-back beats; caller lowers it for a gap
  task automatic send_frag(frag_t f);
    start <= 1;
    in_message_key <= f.key;
    in_seq_num <= f.seq;
    in_first_seq_known <= f.fsk;
    in_first_seq <= f.first_seq;
    in_is_final <= f.fin;
    in_total_len <= f.tlen;
    in_total_frags <= f.tfrags;
    in_data_len <= f.dlen;
    in_rx_time <= f.rx;
    do @(posedge clk); while (busy);
    ledger.note_fragment(f);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; set_mode lowers it
  task automatic write_reg(frt_pkg::cfg_idx_t idx, bit [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    ledger.write_reg(idx, v);
  endtask

  task automatic set_mode(bit ooo, bit wen, bit [6:0] wv, bit [31:0] tmo, bit [15:0] ci);
    drain();
    write_reg(frt_pkg::CFG_OOO, ooo);
    write_reg(frt_pkg::CFG_WRAP_EN, wen);
    write_reg(frt_pkg::CFG_WRAP_VAL, wv);
    write_reg(frt_pkg::CFG_TIMEOUT, tmo);
    write_reg(frt_pkg::CFG_INTERVAL, ci);
    cfg_we <= 0;
  endtask

  function automatic frag_t mk(bit [31:0] k, int s, bit fin, int tl, int tf, int dl, bit [31:0] rx);
    frag_t f;
    f.key = k; f.seq = 6'(s); f.fsk = 0; f.first_seq = 0; f.fin = fin;
    f.tlen = 16'(tl); f.tfrags = 7'(tf); f.dlen = 12'(dl); f.rx = rx;
    return f;
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    int r, k, wv;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 19);
    f.key = (r < 4) ? $urandom : key_pool[k];
    if (ledger.ooo)
      f.seq = 6'($urandom_range(0, 99) < 85 ? $urandom_range(0, 9) : $urandom_range(0, 63));
    else f.seq = r < 78 ? 6'(next_seq[k]) : 6'($urandom_range(0, 63));
    f.fsk = $urandom_range(0, 99) < 25;
    f.first_seq = $urandom_range(0, 1) ? f.seq : 6'($urandom_range(0, 63));
    f.fin = $urandom_range(0, 99) < 15;
    r = $urandom_range(0, 99);
    f.tlen = 16'(r < 20 ? $urandom_range(1, 6000) : r < 24 ? $urandom_range(0, 65535) : 0);
    r = $urandom_range(0, 99);
    f.tfrags = 7'(r < 20 ? $urandom_range(1, 8) : r < 23 ? $urandom_range(0, 64) : 0);
    f.dlen = $urandom_range(0, 99) < 5 ? 12'hFFF : 12'($urandom_range(0, 1500));
    r = $urandom_range(0, 99);
    if (r < 2) now_ticks = $urandom;
    else if (r < 6) now_ticks += $urandom_range(0, 3000);
    else now_ticks += $urandom_range(0, 30);
    f.rx = $urandom_range(0, 99) < 3 ? now_ticks - $urandom_range(0, 500) : now_ticks;
    wv = (ledger.wrap_en && ledger.wrap_val >= 1 && ledger.wrap_val <= 64) ?
         int'(ledger.wrap_val) : 64;
    if (f.key == key_pool[k])
      next_seq[k] = (f.fin || f.seq + 1 >= wv) ? 0 : f.seq + 1;
    return f;
  endfunction

  task automatic run_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_frag(rand_frag());
        burst--; count--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  initial begin
    frag_t f;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      next_seq[i] = 0;
    end
    now_ticks = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // in-order basics under reset settings
    send_frag(mk(32'hA, 0, 0, 0, 0, 10, 10));
    send_frag(mk(32'hA, 1, 0, 0, 0, 20, 11));
    send_frag(mk(32'hA, 1, 0, 0, 0, 20, 12));     // repeat of last seq
    send_frag(mk(32'hA, 2, 1, 0, 0, 5, 13));      // final closes it
    f = mk(32'hB, 3, 0, 0, 0, 1, 14); f.fsk = 1; f.first_seq = 5;
    send_frag(f);                                 // starts mid-message
    send_frag(mk(32'hC, 0, 1, 0, 0, 1, 15));      // lone final fragment
    send_frag(mk(32'hD, 0, 0, 0, 0, 1, 16));
    send_frag(mk(32'hD, 2, 0, 0, 0, 1, 17));      // gap
    send_frag(mk(32'hE, 0, 0, 100, 0, 60, 18));
    send_frag(mk(32'hE, 1, 0, 100, 0, 60, 19));   // length reached
    send_frag(mk(32'hF, 0, 0, 0, 2, 1, 20));
    send_frag(mk(32'hF, 1, 0, 0, 2, 1, 21));      // count reached
    send_frag(mk(32'h7, 0, 0, 0, 0, 1, 0));
    send_frag(mk(32'h7, 1, 0, 0, 0, 1, 5000));    // stale entry restarts
    f = mk(32'hFFFFFFFF, 63, 0, 65535, 64, 4095, 32'hFFFFFFFF); f.fsk = 1; f.first_seq = 63;
    send_frag(f);
    send_frag(mk(32'h0, 0, 0, 0, 0, 4095, 32'hFFFFFFF0));
    now_ticks = 6000;
    run_random(100);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: set_mode(1, 0, 64, 1000, 100);
        1: set_mode(0, 1, 4, 500, 1);
        2: set_mode(0, 1, 64, 32'hFFFFFFFF, 16'hFFFF);
        3: set_mode(0, 1, 0, 200, 0);
        4: set_mode(1, 1, 64, 1000, 100);
        5: set_mode(0, 0, 64, 0, 100);
        6: set_mode(0, 1, 7'h7F, 1, 3);
        default: begin
          bit o;
          o = 1'($urandom_range(0, 1));
          set_mode(o, o ? 1'b0 : 1'($urandom_range(0, 1)), 7'($urandom_range(1, 64)),
                   $urandom_range(20, 3000), 16'($urandom_range(1, 200)));
        end
      endcase
      foreach (next_seq[i]) next_seq[i] = 0;
      run_random((p == 4 || p == 5) ? 20 : 130);
    end

    drain();
    repeat (100) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: fragment_reassembly_tracker_top.f
rtl/frt_pkg.sv
rtl/frt_ram.sv
rtl/fragment_reassembly_tracker_top.sv
rtl/frt_checker.sv
tb/tb.sv
